// ===== rtl/fav_pkg.sv =====
// Shared types, constants and helper functions for the flow arrow vertex builder.
// Used by every module under rtl; depends on nothing else.
package fav_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_NW     = 44;
	localparam int DIV_DW     = 24;
	localparam int CRD_W      = 34;
	localparam int COR_W      = 36;
	localparam int COR_STEPS  = 14;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MAG      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_FRAC    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_COS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_SIN     = 3'd7;

	localparam logic [2:0] SLOT_LAST = 3'd5;

	typedef struct packed {
		logic [15:0]        origin_col;
		logic [15:0]        origin_row;
		logic signed [15:0] flow_dx;
		logic signed [15:0] flow_dy;
		logic [15:0]        flow_magnitude;
	} fav_in_t;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [2:0]         vertex_slot;
		logic               last;
	} fav_out_t;

	typedef struct packed {
		logic [15:0] origin_col;
		logic [15:0] origin_row;
		logic [15:0] dx_mag;
		logic        dx_neg;
		logic [15:0] dy_mag;
		logic        dy_neg;
		logic [15:0] flow_magnitude;
	} fav_item_t;

	typedef struct packed {
		logic [11:0]        frame_width;
		logic [11:0]        frame_height;
		logic [11:0]        arrow_scale;
		logic [12:0]        min_length;
		logic [15:0]        max_flow_magnitude;
		logic [7:0]         head_fraction;
		logic signed [15:0] head_cosine;
		logic signed [15:0] head_sine;
	} fav_cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} fav_div_req_t;

	function automatic logic [13:0] atan_bam(input logic [3:0] i);
		logic [13:0] a;
		case (i)
			4'd0: a = 14'd8192;
			4'd1: a = 14'd4836;
			4'd2: a = 14'd2555;
			4'd3: a = 14'd1297;
			4'd4: a = 14'd651;
			4'd5: a = 14'd326;
			4'd6: a = 14'd163;
			4'd7: a = 14'd81;
			4'd8: a = 14'd41;
			4'd9: a = 14'd20;
			4'd10: a = 14'd10;
			4'd11: a = 14'd5;
			4'd12: a = 14'd3;
			4'd13: a = 14'd1;
			default: a = 14'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		logic signed [15:0] r;
		if (v > 40'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -40'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Divide by 2^22, rounding to nearest with ties away from zero.
	function automatic logic signed [35:0] round_shr22(input logic signed [57:0] v);
		logic [57:0] m;
		logic [35:0] q;
		m = v[57] ? 58'(-v) : 58'(v);
		m = m + 58'd2097152;
		q = m[57:22];
		return v[57] ? -$signed(q) : $signed(q);
	endfunction

endpackage

// ===== rtl/fav_front.sv =====
// Front end: accepts flow vectors, splits the displacements into sign and
// magnitude, and holds them in a two-entry queue. Depends on fav_pkg.
module fav_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vec_valid,
	output logic               vec_ready,
	input  fav_pkg::fav_in_t   vec,
	output logic               q_valid,
	output fav_pkg::fav_item_t q_item,
	input  logic               q_pop
);
	import fav_pkg::*;

	fav_item_t  mem_q [2];
	fav_item_t  item;
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign vec_ready = (cnt_q != 2'd2);
	assign push      = vec_valid && vec_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = mem_q[rd_q];

	always_comb begin
		item.origin_col     = vec.origin_col;
		item.origin_row     = vec.origin_row;
		item.dx_neg         = vec.flow_dx[15];
		item.dx_mag         = vec.flow_dx[15] ? (~vec.flow_dx + 16'd1) : vec.flow_dx;
		item.dy_neg         = vec.flow_dy[15];
		item.dy_mag         = vec.flow_dy[15] ? (~vec.flow_dy + 16'd1) : vec.flow_dy;
		item.flow_magnitude = vec.flow_magnitude;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== rtl/fav_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on fav_pkg for its widths and request type.
module fav_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fav_pkg::fav_div_req_t     req,
	output logic                      done,
	output logic [fav_pkg::DIV_NW-1:0] quo
);
	import fav_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW:0]   trial;

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			quo_q <= req.num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DIV_DW]) begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fav_cordic.sv =====
// Vectoring CORDIC that turns a vector into a 16-bit binary angle.
// Normalizes by one doubling per cycle, then rotates one step per cycle.
// Depends on fav_pkg for widths and the arctangent table.
module fav_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [fav_pkg::CRD_W-1:0] x_in,
	input  logic signed [fav_pkg::CRD_W-1:0] y_in,
	output logic                            done,
	output logic [15:0]                     hue
);
	import fav_pkg::*;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_NORM = 2'd1;
	localparam logic [1:0] C_ROT  = 2'd2;
	localparam logic signed [COR_W-1:0] NORM_LIM = COR_W'(2 ** 29);
	localparam logic [3:0] LAST_STEP = 4'(COR_STEPS - 1);

	logic [1:0]              st_q;
	logic [3:0]              i_q;
	logic                    done_q;
	logic signed [COR_W-1:0] x_q;
	logic signed [COR_W-1:0] y_q;
	logic [15:0]             z_q;
	logic signed [COR_W-1:0] xe;
	logic signed [COR_W-1:0] ye;
	logic signed [COR_W-1:0] ax;
	logic signed [COR_W-1:0] ay;
	logic signed [COR_W-1:0] xs;
	logic signed [COR_W-1:0] ys;
	logic                    small_vec;

	assign xe        = COR_W'(x_in);
	assign ye        = COR_W'(y_in);
	assign ax        = x_q[COR_W-1] ? -x_q : x_q;
	assign ay        = y_q[COR_W-1] ? -y_q : y_q;
	assign small_vec = (ax < NORM_LIM) && (ay < NORM_LIM);
	assign xs        = x_q >>> i_q;
	assign ys        = y_q >>> i_q;
	assign done      = done_q;
	assign hue       = z_q;

	always_ff @(posedge clk) begin
		if (start) begin
			if (xe < 0) begin
				x_q <= -xe;
				y_q <= -ye;
				z_q <= 16'h8000;
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= 16'h0000;
			end
		end else if (st_q == C_NORM) begin
			if (small_vec) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end
		end else if (st_q == C_ROT) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + 16'(atan_bam(i_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - 16'(atan_bam(i_q));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_IDLE;
			i_q    <= 4'd0;
			done_q <= 1'b0;
		end else if (start) begin
			i_q <= 4'd0;
			if (x_in == '0 && y_in == '0) begin
				st_q   <= C_IDLE;
				done_q <= 1'b1;
			end else begin
				st_q   <= C_NORM;
				done_q <= 1'b0;
			end
		end else begin
			unique case (st_q)
				C_NORM: begin
					if (!small_vec) begin
						st_q <= C_ROT;
					end
				end
				C_ROT: begin
					i_q <= i_q + 4'd1;
					if (i_q == LAST_STEP) begin
						st_q   <= C_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/fav_back.sv =====
// Back end: maps one queued flow vector to NDC and tests its length; unless the
// arrow is too short, builds the arrowhead and HSV colour and sends six vertices
// through an output register. Depends on fav_pkg, fav_div and fav_cordic.
module fav_back #(
	parameter int NDC_FRAC_BITS = 12,
	parameter int COLOR_BITS    = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fav_pkg::fav_cfg_t  cfg,
	input  logic               q_valid,
	input  fav_pkg::fav_item_t q_item,
	output logic               q_pop,
	output logic               vtx_valid,
	input  logic               vtx_ready,
	output fav_pkg::fav_out_t  vtx
);
	import fav_pkg::*;

	localparam int CB = COLOR_BITS;
	localparam logic [CB-1:0] VMAX = '1;
	localparam logic signed [CRD_W-1:0] ONE_NDC = CRD_W'(2 ** NDC_FRAC_BITS);

	localparam int DV_X0 = 0;
	localparam int DV_Y0 = 1;
	localparam int DV_SX = 2;
	localparam int DV_SY = 3;
	localparam int DV_V  = 4;
	localparam int NDIV  = 5;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_SIGN  = 4'd3;
	localparam logic [3:0] S_SQR   = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_WING  = 4'd6;
	localparam logic [3:0] S_CWAIT = 4'd7;
	localparam logic [3:0] S_VF    = 4'd8;
	localparam logic [3:0] S_COL   = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;

	logic [3:0]              state_q;
	fav_item_t               item_q;
	fav_div_req_t            req_q [NDIV];
	logic [NDIV-1:0]         div_done;
	logic [DIV_NW-1:0]       div_quo [NDIV];
	logic [11:0]             w_eff;
	logic [11:0]             h_eff;
	logic [15:0]             m_eff;
	logic [27:0]             pdx;
	logic [27:0]             pdy;
	logic [27:0]             pv;
	logic signed [CRD_W-1:0] x0_q;
	logic signed [CRD_W-1:0] y0_q;
	logic signed [CRD_W-1:0] sdx_q;
	logic signed [CRD_W-1:0] sdy_q;
	logic signed [CRD_W-1:0] x1_q;
	logic signed [CRD_W-1:0] y1_q;
	logic signed [CRD_W-1:0] neg_sdx;
	logic signed [CRD_W-1:0] sm_x;
	logic signed [CRD_W-1:0] sm_y;
	logic [CRD_W-2:0]        ax;
	logic [CRD_W-2:0]        ay;
	logic [CB-1:0]           v_q;
	logic [61:0]             sqx_q;
	logic [61:0]             sqy_q;
	logic [25:0]             mlsq_q;
	logic [62:0]             sqsum;
	logic signed [49:0]      pxc_q;
	logic signed [49:0]      pxs_q;
	logic signed [49:0]      pyc_q;
	logic signed [49:0]      pys_q;
	logic signed [50:0]      a1_q;
	logic signed [50:0]      b1_q;
	logic signed [50:0]      a2_q;
	logic signed [50:0]      b2_q;
	logic signed [57:0]      wa1_q;
	logic signed [57:0]      wb1_q;
	logic signed [57:0]      wa2_q;
	logic signed [57:0]      wb2_q;
	logic signed [8:0]       hf_s;
	logic                    cor_start_q;
	logic                    cor_done;
	logic [15:0]             hue;
	logic [18:0]             hh;
	logic [2:0]              sector_q;
	logic [15:0]             f_q;
	logic [CB+15:0]          vf_q;
	logic [CB+15:0]          tsum;
	logic [CB-1:0]           t_c;
	logic [CB-1:0]           qv_c;
	logic [CB-1:0]           r_q;
	logic [CB-1:0]           g_q;
	logic [CB-1:0]           b_q;
	logic signed [15:0]      x0s_q;
	logic signed [15:0]      y0s_q;
	logic signed [15:0]      x1s_q;
	logic signed [15:0]      y1s_q;
	logic signed [15:0]      x3s_q;
	logic signed [15:0]      y3s_q;
	logic signed [15:0]      x5s_q;
	logic signed [15:0]      y5s_q;
	logic [2:0]              k_q;
	logic                    out_valid_q;
	fav_out_t                out_q;
	fav_out_t                vert;
	logic                    load;

	assign w_eff = (cfg.frame_width == 12'd0) ? 12'd1 : cfg.frame_width;
	assign h_eff = (cfg.frame_height == 12'd0) ? 12'd1 : cfg.frame_height;
	assign m_eff = (cfg.max_flow_magnitude == 16'd0) ? 16'd1 : cfg.max_flow_magnitude;
	assign pdx   = 28'(item_q.dx_mag) * 28'(cfg.arrow_scale);
	assign pdy   = 28'(item_q.dy_mag) * 28'(cfg.arrow_scale);
	assign pv    = 28'(item_q.flow_magnitude) * 28'(VMAX);

	assign sm_x    = $signed({1'b0, div_quo[DV_SX][CRD_W-2:0]});
	assign sm_y    = $signed({1'b0, div_quo[DV_SY][CRD_W-2:0]});
	assign ax      = sdx_q[CRD_W-1] ? (CRD_W-1)'(-sdx_q) : (CRD_W-1)'(sdx_q);
	assign ay      = sdy_q[CRD_W-1] ? (CRD_W-1)'(-sdy_q) : (CRD_W-1)'(sdy_q);
	assign neg_sdx = -sdx_q;
	assign sqsum   = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign hf_s    = $signed({1'b0, cfg.head_fraction});
	assign hh      = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
	assign tsum    = vf_q + (CB + 16)'(32768);
	assign t_c     = tsum[CB+15:16];
	assign qv_c    = v_q - t_c;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign load      = (state_q == S_EMIT) && (!out_valid_q || vtx_ready);
	assign vtx_valid = out_valid_q;
	assign vtx       = out_q;

	genvar gi;
	generate
		for (gi = 0; gi < NDIV; gi++) begin : g_div
			fav_div u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.req    (req_q[gi]),
				.done   (div_done[gi]),
				.quo    (div_quo[gi])
			);
		end
	endgenerate

	fav_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start_q),
		.x_in   (sdy_q),
		.y_in   (neg_sdx),
		.done   (cor_done),
		.hue    (hue)
	);

	always_comb begin
		vert.red         = 8'(r_q);
		vert.green       = 8'(g_q);
		vert.blue        = 8'(b_q);
		vert.vertex_slot = k_q;
		vert.last        = (k_q == SLOT_LAST);
		unique case (k_q)
			3'd0: begin
				vert.vertex_x = x0s_q;
				vert.vertex_y = y0s_q;
			end
			3'd3: begin
				vert.vertex_x = x3s_q;
				vert.vertex_y = y3s_q;
			end
			3'd5: begin
				vert.vertex_x = x5s_q;
				vert.vertex_y = y5s_q;
			end
			default: begin
				vert.vertex_x = x1s_q;
				vert.vertex_y = y1s_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		for (int i = 0; i < NDIV; i++) begin
			req_q[i].start <= (state_q == S_PREP);
		end
		if (state_q == S_PREP) begin
			req_q[DV_X0].num <= (DIV_NW'(item_q.origin_row) << (NDC_FRAC_BITS - 3))
				+ DIV_NW'(h_eff >> 1);
			req_q[DV_X0].den <= DIV_DW'(h_eff);
			req_q[DV_Y0].num <= (DIV_NW'(item_q.origin_col) << (NDC_FRAC_BITS - 3))
				+ DIV_NW'(w_eff >> 1);
			req_q[DV_Y0].den <= DIV_DW'(w_eff);
			req_q[DV_SX].num <= (DIV_NW'(pdy) << (NDC_FRAC_BITS + 1))
				+ (DIV_NW'(h_eff) << 11);
			req_q[DV_SX].den <= DIV_DW'(h_eff) << 12;
			req_q[DV_SY].num <= (DIV_NW'(pdx) << (NDC_FRAC_BITS + 1))
				+ (DIV_NW'(w_eff) << 11);
			req_q[DV_SY].den <= DIV_DW'(w_eff) << 12;
			req_q[DV_V].num  <= DIV_NW'(pv) + DIV_NW'(m_eff >> 1);
			req_q[DV_V].den  <= DIV_DW'(m_eff);
		end
		if (state_q == S_SIGN) begin
			x0_q  <= $signed({1'b0, div_quo[DV_X0][CRD_W-2:0]}) - ONE_NDC;
			y0_q  <= $signed({1'b0, div_quo[DV_Y0][CRD_W-2:0]}) - ONE_NDC;
			sdx_q <= item_q.dy_neg ? -sm_x : sm_x;
			sdy_q <= item_q.dx_neg ? -sm_y : sm_y;
			v_q   <= (div_quo[DV_V] > DIV_NW'(VMAX)) ? VMAX : div_quo[DV_V][CB-1:0];
		end
		if (state_q == S_SQR) begin
			sqx_q  <= {29'd0, ax} * {29'd0, ax};
			sqy_q  <= {29'd0, ay} * {29'd0, ay};
			mlsq_q <= {13'd0, cfg.min_length} * {13'd0, cfg.min_length};
			pxc_q  <= sdx_q * cfg.head_cosine;
			pxs_q  <= sdx_q * cfg.head_sine;
			pyc_q  <= sdy_q * cfg.head_cosine;
			pys_q  <= sdy_q * cfg.head_sine;
			x1_q   <= x0_q + sdx_q;
			y1_q   <= y0_q + sdy_q;
		end
		if (state_q == S_CMP) begin
			a1_q <= 51'(pxc_q) - 51'(pys_q);
			b1_q <= 51'(pxs_q) + 51'(pyc_q);
			a2_q <= 51'(pxc_q) + 51'(pys_q);
			b2_q <= 51'(pyc_q) - 51'(pxs_q);
		end
		if (state_q == S_WING) begin
			wa1_q <= 58'(a1_q) * hf_s;
			wb1_q <= 58'(b1_q) * hf_s;
			wa2_q <= 58'(a2_q) * hf_s;
			wb2_q <= 58'(b2_q) * hf_s;
		end
		if (state_q == S_CWAIT) begin
			sector_q <= hh[18:16];
			f_q      <= hh[15:0];
		end
		if (state_q == S_VF) begin
			vf_q <= (CB + 16)'(v_q) * (CB + 16)'(f_q);
		end
		if (state_q == S_COL) begin
			unique case (sector_q)
				3'd0: begin
					r_q <= v_q;
					g_q <= t_c;
					b_q <= '0;
				end
				3'd1: begin
					r_q <= qv_c;
					g_q <= v_q;
					b_q <= '0;
				end
				3'd2: begin
					r_q <= '0;
					g_q <= v_q;
					b_q <= t_c;
				end
				3'd3: begin
					r_q <= '0;
					g_q <= qv_c;
					b_q <= v_q;
				end
				3'd4: begin
					r_q <= t_c;
					g_q <= '0;
					b_q <= v_q;
				end
				default: begin
					r_q <= v_q;
					g_q <= '0;
					b_q <= qv_c;
				end
			endcase
			x0s_q <= sat16(40'(x0_q));
			y0s_q <= sat16(40'(y0_q));
			x1s_q <= sat16(40'(x1_q));
			y1s_q <= sat16(40'(y1_q));
			x3s_q <= sat16(40'(x1_q) - 40'(round_shr22(wa1_q)));
			y3s_q <= sat16(40'(y1_q) - 40'(round_shr22(wb1_q)));
			x5s_q <= sat16(40'(x1_q) - 40'(round_shr22(wa2_q)));
			y5s_q <= sat16(40'(y1_q) - 40'(round_shr22(wb2_q)));
		end
		if (load) begin
			out_q <= vert;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cor_start_q <= 1'b0;
			k_q         <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			cor_start_q <= 1'b0;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (vtx_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_DIV;
				S_DIV: begin
					if (!req_q[DV_X0].start && (&div_done)) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: state_q <= S_SQR;
				S_SQR:  state_q <= S_CMP;
				S_CMP: begin
					if (sqsum < 63'(mlsq_q)) begin
						state_q <= S_IDLE;
					end else begin
						cor_start_q <= 1'b1;
						state_q     <= S_WING;
					end
				end
				S_WING: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (!cor_start_q && cor_done) begin
						state_q <= S_VF;
					end
				end
				S_VF: state_q <= S_COL;
				S_COL: begin
					k_q     <= 3'd0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load) begin
						k_q <= k_q + 3'd1;
						if (k_q == SLOT_LAST) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/flow_arrow_vertex_builder.sv =====
// Top level of the flow arrow vertex builder: configuration registers, front
// queue and back end. Depends on fav_pkg, fav_front and fav_back.
//
// Each accepted flow vector produces either nothing (arrow shorter than
// min_length) or six line vertices, shaft first and then the two arrowhead
// wings, all in one colour. In the back end the five 44-step serial dividers
// that place the origin, scale the displacement and set the brightness run in
// parallel, a dropped arrow ends after the length test, and a drawn arrow then
// adds the CORDIC hue search (2 to 29 normalizing doublings plus 14 rotation
// steps, none for a zero-length arrow) and the output of its six vertices.
// A two-entry queue in front takes new vectors while the back end works, and
// the output register lets the next vector start while the last vertex waits
// to be taken. Configuration is written with cfg_wen, cfg_index and cfg_data
// and should only change while no vector is in flight.
module flow_arrow_vertex_builder #(
	parameter int NDC_FRAC_BITS = 12,
	parameter int COLOR_BITS    = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vec_valid,
	output logic                               vec_ready,
	input  fav_pkg::fav_in_t                   vec,
	output logic                               vtx_valid,
	input  logic                               vtx_ready,
	output fav_pkg::fav_out_t                  vtx,
	input  logic                               cfg_wen,
	input  logic [fav_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fav_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fav_pkg::*;

	fav_cfg_t  cfg_q;
	logic      q_valid;
	fav_item_t q_item;
	logic      q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width        <= 12'd640;
			cfg_q.frame_height       <= 12'd480;
			cfg_q.arrow_scale        <= 12'd256;
			cfg_q.min_length         <= 13'd41;
			cfg_q.max_flow_magnitude <= 16'd320;
			cfg_q.head_fraction      <= 8'd77;
			cfg_q.head_cosine        <= 16'sd14849;
			cfg_q.head_sine          <= 16'sd6924;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width        <= cfg_data[11:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height       <= cfg_data[11:0];
				REG_ARROW_SCALE:  cfg_q.arrow_scale        <= cfg_data[11:0];
				REG_MIN_LENGTH:   cfg_q.min_length         <= cfg_data[12:0];
				REG_MAX_MAG:      cfg_q.max_flow_magnitude <= cfg_data;
				REG_HEAD_FRAC:    cfg_q.head_fraction      <= cfg_data[7:0];
				REG_HEAD_COS:     cfg_q.head_cosine        <= $signed(cfg_data);
				REG_HEAD_SIN:     cfg_q.head_sine          <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	fav_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_valid (vec_valid),
		.vec_ready (vec_ready),
		.vec       (vec),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	fav_back #(
		.NDC_FRAC_BITS (NDC_FRAC_BITS),
		.COLOR_BITS    (COLOR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx)
	);

`ifndef SYNTH
	// The last flag marks the final vertex of an arrow and nothing else.
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> (vtx.last == (vtx.vertex_slot == SLOT_LAST)))
		else $error("last flag does not match vertex slot");

	// Vertices of one arrow leave in slot order.
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid && vtx_ready && !vtx.last) |=>
		(!vtx_valid || (vtx.vertex_slot == $past(vtx.vertex_slot) + 3'd1)))
		else $error("vertex slot out of order");

	// With full saturation at least one colour channel is zero.
	a_hsv_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> (vtx.red == 8'd0 || vtx.green == 8'd0 || vtx.blue == 8'd0))
		else $error("no colour channel at zero");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the flow arrow vertex builder.
// It predicts every vertex from the flow vector and the register settings and
// compares each output transaction in order. Depends on fav_pkg and the RTL.
module testbench;
	import fav_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;
	localparam int SETTLE_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vec_valid = 1'b0;
	logic vec_ready;
	fav_in_t vec = '0;
	logic vtx_valid;
	logic vtx_ready = 1'b0;
	fav_out_t vtx;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fav_out_t pending_vertices[$];
	int mismatches = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic rx_hold = 1'b0;

	logic [11:0] sh_width = 12'd640, sh_height = 12'd480, sh_scale = 12'd256;
	logic [12:0] sh_min_len = 13'd41;
	logic [15:0] sh_max_mag = 16'd320;
	logic [7:0] sh_head_frac = 8'd77;
	logic [15:0] sh_head_cos = 16'd14849, sh_head_sin = 16'd6924;

	flow_arrow_vertex_builder DUT (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
		.vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx(vtx),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		vtx_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	function automatic longint round_div(longint n, longint d);
		if (n >= 0) return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic logic [15:0] clamp_q3_12(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic logic [15:0] direction_angle(longint x, longint y);
		int unsigned steps[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
			10, 5, 3, 1};
		int unsigned z = 0;
		longint xs, ys;
		if (x == 0 && y == 0) return 16'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32768;
		end
		while ((x < 0 ? -x : x) < (64'sd1 <<< 29) && (y < 0 ? -y : y) < (64'sd1 <<< 29)) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < 14; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + steps[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - steps[i];
			end
		end
		return z[15:0];
	endfunction

	task automatic build_arrow_vertices(input fav_in_t item);
		longint w, h, mmax, x0, y0, sdx, sdy, x1, y1, c, s, hf, v, t, q, r, g, b;
		longint vx[6], vy[6];
		int unsigned hh, sector, f;
		fav_out_t o;
		w = (sh_width == 0) ? 1 : longint'(sh_width);
		h = (sh_height == 0) ? 1 : longint'(sh_height);
		mmax = (sh_max_mag == 0) ? 1 : longint'(sh_max_mag);
		c = longint'($signed(sh_head_cos));
		s = longint'($signed(sh_head_sin));
		hf = longint'(sh_head_frac);
		x0 = round_div(longint'(item.origin_row) * 512, h) - 4096;
		y0 = round_div(longint'(item.origin_col) * 512, w) - 4096;
		sdx = round_div(longint'(item.flow_dy) * longint'(sh_scale) * 8192, 4096 * h);
		sdy = round_div(longint'(item.flow_dx) * longint'(sh_scale) * 8192, 4096 * w);
		if (sdx * sdx + sdy * sdy < longint'(sh_min_len) * longint'(sh_min_len)) return;
		x1 = x0 + sdx;
		y1 = y0 + sdy;
		hh = direction_angle(sdy, -sdx) * 6;
		sector = hh >> 16;
		f = hh & 32'hFFFF;
		v = round_div(longint'(item.flow_magnitude) * 255, mmax);
		if (v > 255) v = 255;
		t = (v * longint'(f) + 32768) >>> 16;
		q = v - t;
		case (sector)
			0: begin r = v; g = t; b = 0; end
			1: begin r = q; g = v; b = 0; end
			2: begin r = 0; g = v; b = t; end
			3: begin r = 0; g = q; b = v; end
			4: begin r = t; g = 0; b = v; end
			default: begin r = v; g = 0; b = q; end
		endcase
		vx[0] = x0; vy[0] = y0;
		vx[1] = x1; vy[1] = y1;
		vx[2] = x1; vy[2] = y1;
		vx[3] = x1 - round_div((sdx * c - sdy * s) * hf, 64'sd1 <<< 22);
		vy[3] = y1 - round_div((sdx * s + sdy * c) * hf, 64'sd1 <<< 22);
		vx[4] = x1; vy[4] = y1;
		vx[5] = x1 - round_div((sdx * c + sdy * s) * hf, 64'sd1 <<< 22);
		vy[5] = y1 - round_div((sdy * c - sdx * s) * hf, 64'sd1 <<< 22);
		for (int k = 0; k < 6; k++) begin
			o.vertex_x = clamp_q3_12(vx[k]);
			o.vertex_y = clamp_q3_12(vy[k]);
			o.red = r[7:0];
			o.green = g[7:0];
			o.blue = b[7:0];
			o.vertex_slot = 3'(k);
			o.last = (3'(k) == SLOT_LAST);
			pending_vertices = {pending_vertices, o};
		end
	endtask

	always @(posedge clk) begin
		fav_out_t e;
		if (arst_n && vtx_valid && vtx_ready) begin
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected vertex transaction: %p", vtx);
			end else begin
				e = pending_vertices.pop_front();
				if (vtx.vertex_x !== e.vertex_x || vtx.vertex_y !== e.vertex_y ||
					vtx.red !== e.red || vtx.green !== e.green || vtx.blue !== e.blue ||
					vtx.vertex_slot !== e.vertex_slot || vtx.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10) $display("Vertex mismatch: expected %p, got %p", e, vtx);
				end
			end
		end
	end

	task automatic send_vector(input fav_in_t item);
		while ($urandom_range(99) < tx_idle_pct) begin
			vec_valid <= 1'b0;
			@(posedge clk);
		end
		vec <= item;
		vec_valid <= 1'b1;
		build_arrow_vertices(item);
		@(posedge clk);
		while (!vec_ready) @(posedge clk);
	endtask

	task automatic settle();
		vec_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FRAME_WIDTH: sh_width = val[11:0];
			REG_FRAME_HEIGHT: sh_height = val[11:0];
			REG_ARROW_SCALE: sh_scale = val[11:0];
			REG_MIN_LENGTH: sh_min_len = val[12:0];
			REG_MAX_MAG: sh_max_mag = val;
			REG_HEAD_FRAC: sh_head_frac = val[7:0];
			REG_HEAD_COS: sh_head_cos = val;
			default: sh_head_sin = val;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input int wd, ht, sc, ml, mm, hfr, hc, hs);
		write_reg(REG_FRAME_WIDTH, 16'(wd));
		write_reg(REG_FRAME_HEIGHT, 16'(ht));
		write_reg(REG_ARROW_SCALE, 16'(sc));
		write_reg(REG_MIN_LENGTH, 16'(ml));
		write_reg(REG_MAX_MAG, 16'(mm));
		write_reg(REG_HEAD_FRAC, 16'(hfr));
		write_reg(REG_HEAD_COS, 16'(hc));
		write_reg(REG_HEAD_SIN, 16'(hs));
	endtask

	function automatic fav_in_t make_vector(int col, row, dx, dy, mag);
		fav_in_t v;
		v.origin_col = 16'(col);
		v.origin_row = 16'(row);
		v.flow_dx = 16'(dx);
		v.flow_dy = 16'(dy);
		v.flow_magnitude = 16'(mag);
		return v;
	endfunction

	function automatic fav_in_t random_vector();
		fav_in_t v;
		v = fav_in_t'({$urandom, $urandom, $urandom});
		if ($urandom_range(3) != 0) begin
			v.flow_dx = 16'($signed(12'($urandom)));
			v.flow_dy = 16'($signed(12'($urandom)));
		end
		if ($urandom_range(1) == 0) v.flow_magnitude = 16'($urandom_range(1023));
		return v;
	endfunction

	task automatic random_config();
		int ml;
		ml = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(200);
		write_all($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(4095), ml,
			$urandom_range(1, 65535), $urandom_range(255),
			$urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
	endtask

	task automatic test_directed_extremes();
		send_vector(make_vector(0, 0, 0, 0, 0));
		send_vector(make_vector(65535, 65535, 32767, 32767, 65535));
		send_vector(make_vector(10240, 7680, -32768, -32768, 320));
		send_vector(make_vector(5120, 3840, 800, 0, 160));
		send_vector(make_vector(5120, 3840, -800, 0, 640));
		send_vector(make_vector(5120, 3840, 0, 800, 100));
		send_vector(make_vector(5120, 3840, 0, -800, 319));
		send_vector(make_vector(5120, 3840, 600, -600, 321));
		send_vector(make_vector(5120, 3840, 20, 10, 200));
		send_vector(make_vector(0, 65535, 32767, -32768, 1));
		settle();
		write_all(0, 0, 4095, 0, 0, 255, -16384, 16384);
		send_vector(make_vector(0, 0, 0, 0, 300));
		send_vector(make_vector(65535, 0, 1, -1, 0));
		send_vector(make_vector(1, 65535, -32768, 32767, 65535));
		send_vector(make_vector(32768, 32768, 3, 5, 7));
		settle();
		write_all(4095, 4095, 0, 8191, 65535, 0, 16384, -16384);
		send_vector(make_vector(65535, 65535, 32767, 32767, 65535));
		settle();
		write_all(4095, 4095, 4095, 8191, 65535, 255, 16384, -16384);
		send_vector(make_vector(65535, 65535, 32767, 32767, 65535));
		send_vector(make_vector(0, 0, -32768, -32768, 65535));
		send_vector(make_vector(100, 200, 32767, -32768, 32768));
		settle();
	endtask

	task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				settle();
				random_config();
			end
			send_vector(random_vector());
		end
		settle();
	endtask

	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_all(640, 480, 256, 0, 320, 77, 14849, 6924);
		fork
			begin
				@(posedge clk);
				rx_hold <= 1'b1;
				repeat (800) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 12; i++) begin
			send_vector(make_vector($urandom, $urandom, 200 + i, -300 + i, $urandom));
		end
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_random_traffic(150, 35, 50);
		test_random_traffic(150, 50, 35);
		test_random_traffic(130, 0, 0);
		test_output_backpressure();
		if (mismatches == 0 && pending_vertices.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fav_pkg.sv
rtl/fav_front.sv
rtl/fav_div.sv
rtl/fav_cordic.sv
rtl/fav_back.sv
rtl/flow_arrow_vertex_builder.sv
tb/testbench.sv
